// ===== design/qgi_pkg.sv =====
`timescale 1ns / 1ps
// Package for the quaternion gyro integrator: pipeline item type, stage layout,
// fixed-point constants and the arctangent table. No dependencies.
package qgi_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_FRAC_BITS    = 30;
  localparam int DEF_CORDIC_STEPS = 24;
  localparam logic [31:0] PERIOD_RESET = 32'd4294967;

  // Angle constants, Q.30 radians
  localparam logic [42:0]        TWO_PI_W     = 43'd6746518852;
  localparam logic signed [35:0] TWO_PI_S     = 36'sd6746518852;
  localparam logic signed [35:0] PI_S         = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_S    = 36'sd1686629713;
  localparam logic signed [35:0] CORDIC_START = 36'sd652032874;
  localparam logic signed [35:0] ONE_S        = 36'sd1073741824;
  localparam logic [31:0]        ONE_Q30      = 32'd1073741824;

  // Truncated atan(2^-i), Q.30
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
  };

  // Stage layout, first half (rotation vector, angle, delta quaternion)
  localparam int S_MUL      = 0;
  localparam int S_RV       = 1;
  localparam int S_LZC      = 2;
  localparam int S_SCALE    = 3;
  localparam int S_SQR      = 4;
  localparam int S_SUM      = 5;
  localparam int S_SQRT     = 6;
  localparam int ROOT_STEPS = 32;
  localparam int S_ANG      = S_SQRT + ROOT_STEPS;
  localparam int S_DIV      = S_ANG + 1;
  localparam int DIV_STEPS  = 32;
  localparam int S_MOD      = S_ANG + 1;
  localparam int MOD_STEPS  = 10;
  localparam int S_FOLD     = S_MOD + MOD_STEPS;
  localparam int S_CORD     = S_FOLD + 1;

  // Second half, offsets from the join stage
  localparam int E_SIN   = 0;
  localparam int E_MULS  = 1;
  localparam int E_DQ    = 2;
  localparam int E_PROD  = 3;
  localparam int E_PSUM  = 4;
  localparam int E_LZC   = 5;
  localparam int E_SCALE = 6;
  localparam int E_SQR   = 7;
  localparam int E_SUM   = 8;
  localparam int E_SQRT  = 9;
  localparam int E_NORM  = E_SQRT + ROOT_STEPS;
  localparam int E_DIV   = E_NORM + 1;
  localparam int E_OUT   = E_DIV + DIV_STEPS;

  // Join stage: both the divider and the CORDIC run are done
  function automatic int stage_e(int cs);
    return (S_CORD + cs > S_DIV + DIV_STEPS) ? S_CORD + cs : S_DIV + DIV_STEPS;
  endfunction

  function automatic int num_stages(int cs);
    return stage_e(cs) + E_OUT + 1;
  endfunction

  function automatic logic signed [63:0] sx62(logic [61:0] v);
    return {{2{v[61]}}, v};
  endfunction

  // One item as it moves down the chain
  typedef struct packed {
    logic [3:0][31:0]  q;
    logic [2:0][31:0]  rate;
    logic [2:0][63:0]  prod;
    logic [2:0]        rvneg;
    logic              rvzero;
    logic [3:0][61:0]  mag;
    logic [61:0]       mx;
    logic [6:0]        k;
    logic [3:0][30:0]  m;
    logic [3:0][61:0]  sq;
    logic [63:0]       rad;
    logic [35:0]       srem;
    logic [31:0]       root;
    logic [42:0]       h;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [35:0] cz;
    logic              cneg;
    logic [3:0][31:0]  drem;
    logic [3:0][31:0]  dlo;
    logic [3:0][31:0]  quo;
    logic [31:0]       dden;
    logic [31:0]       sm;
    logic              sneg;
    logic [3:0][31:0]  dq;
    logic [15:0][61:0] pt;
    logic [3:0]        pneg;
    logic              pzero;
    logic [3:0][31:0]  res;
  } item_t;

endpackage

// ===== design/qgi_cell.sv =====
`timescale 1ns / 1ps
// One cell of the integrator chain: registers one item and applies the step
// chosen by its place in the chain. Depends on qgi_pkg.
module qgi_cell
  import qgi_pkg::*;
#(
  parameter int STEP = 0,
  parameter int CS   = DEF_CORDIC_STEPS,
  parameter int FRAC = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [31:0] period,
  input  item_t       in_item,
  input  logic        in_vld,
  output item_t       out_item,
  output logic        out_vld
);

  localparam int E = stage_e(CS);
  localparam bit DO_LZC   = (STEP == S_LZC) || (STEP == E + E_LZC);
  localparam bit DO_SCALE = (STEP == S_SCALE) || (STEP == E + E_SCALE);
  localparam bit DO_SQR   = (STEP == S_SQR) || (STEP == E + E_SQR);
  localparam bit DO_SUM   = (STEP == S_SUM) || (STEP == E + E_SUM);
  localparam bit DO_SQRT  = (STEP >= S_SQRT && STEP < S_SQRT + ROOT_STEPS) ||
                            (STEP >= E + E_SQRT && STEP < E + E_SQRT + ROOT_STEPS);
  localparam bit DO_DIV   = (STEP >= S_DIV && STEP < S_DIV + DIV_STEPS) ||
                            (STEP >= E + E_DIV && STEP < E + E_DIV + DIV_STEPS);
  localparam bit DO_MOD   = (STEP >= S_MOD && STEP < S_MOD + MOD_STEPS);
  localparam int MOD_J    = DO_MOD ? MOD_STEPS - 1 - (STEP - S_MOD) : 0;
  localparam logic [42:0] MOD_C = TWO_PI_W << MOD_J;
  localparam bit DO_CORD  = (STEP >= S_CORD && STEP < S_CORD + CS);
  localparam int CORD_I   = DO_CORD ? STEP - S_CORD : 0;
  localparam bit DO_INIT  = (STEP == S_ANG) || (STEP == E + E_NORM);
  localparam int NUM_SH   = (STEP == S_ANG) ? 30 : FRAC;
  localparam int NUM_LN   = (STEP == S_ANG) ? 3 : 4;

  item_t nx;
  logic signed [64:0] pw;
  logic signed [64:0] rr;
  logic signed [41:0] rvs;
  logic [41:0]        mg;
  logic [5:0]         pos;
  logic [61:0]        sh;
  logic [42:0]        aa;
  logic [63:0]        nd;
  logic [35:0]        st;
  logic [35:0]        trial;
  logic signed [35:0] tt;
  logic signed [35:0] at;
  logic               fneg;
  logic [32:0]        tq;
  logic [63:0]        vv;
  logic [31:0]        v32;
  logic signed [63:0] pp;
  logic signed [63:0] ps [4];

  // Step logic
  always_comb begin
    nx    = in_item;
    pw    = '0;
    rr    = '0;
    rvs   = '0;
    mg    = '0;
    pos   = '0;
    sh    = '0;
    aa    = '0;
    nd    = '0;
    st    = '0;
    trial = '0;
    tt    = '0;
    at    = '0;
    fneg  = 1'b0;
    tq    = '0;
    vv    = '0;
    v32   = '0;
    pp    = '0;
    for (int i = 0; i < 4; i++) ps[i] = '0;

    // rate times period
    if (STEP == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        pw = $signed(in_item.rate[i]) * $signed({1'b0, period});
        nx.prod[i] = pw[63:0];
      end
    end

    // round to Q.30 radians, magnitudes and their maximum
    if (STEP == S_RV) begin
      for (int i = 0; i < 3; i++) begin
        rr  = $signed({in_item.prod[i][63], in_item.prod[i]}) + 65'sd2097152;
        rvs = rr[63:22];
        mg  = rvs[41] ? (~rvs + 42'd1) : rvs;
        nx.rvneg[i] = rvs[41];
        nx.mag[i]   = {20'd0, mg};
      end
      nx.mag[3]  = '0;
      nx.rvzero  = (nx.mag[0] == '0) && (nx.mag[1] == '0) && (nx.mag[2] == '0);
      nx.mx = nx.mag[0];
      if (nx.mag[1] > nx.mx) nx.mx = nx.mag[1];
      if (nx.mag[2] > nx.mx) nx.mx = nx.mag[2];
    end

    // leading one of the maximum gives the scale shift
    if (DO_LZC) begin
      for (int b = 0; b < 62; b++) begin
        if (in_item.mx[b]) pos = 6'(b);
      end
      nx.k = (in_item.mx == '0) ? 7'd0 : ({1'b0, pos} - 7'd30);
    end

    if (DO_SCALE) begin
      for (int i = 0; i < 4; i++) begin
        if (!in_item.k[6]) sh = in_item.mag[i] >> in_item.k;
        else sh = in_item.mag[i] << (7'd0 - in_item.k);
        nx.m[i] = sh[30:0];
      end
    end

    if (DO_SQR) begin
      for (int i = 0; i < 4; i++) begin
        nx.sq[i] = 62'(in_item.m[i]) * 62'(in_item.m[i]);
      end
    end

    if (DO_SUM) begin
      nx.rad  = 64'(in_item.sq[0]) + 64'(in_item.sq[1]) + 64'(in_item.sq[2]) +
                64'(in_item.sq[3]);
      nx.srem = '0;
      nx.root = '0;
    end

    // one root bit per cell
    if (DO_SQRT) begin
      st    = {in_item.srem[33:0], in_item.rad[63:62]};
      trial = {2'b00, in_item.root, 2'b01};
      if (st >= trial) begin
        nx.srem = st - trial;
        nx.root = {in_item.root[30:0], 1'b1};
      end else begin
        nx.srem = st;
        nx.root = {in_item.root[30:0], 1'b0};
      end
      nx.rad = {in_item.rad[61:0], 2'b00};
    end

    // angle from the root; half angle
    if (STEP == S_ANG) begin
      if (!in_item.k[6]) aa = 43'(in_item.root) << in_item.k;
      else aa = 43'(in_item.root) >> (7'd0 - in_item.k);
      nx.h = (aa + 43'd1) >> 1;
    end

    // divider set-up: ((m << sh) + n/2) / n
    if (DO_INIT) begin
      for (int i = 0; i < 4; i++) begin
        nd = (i < NUM_LN) ? ((64'(in_item.m[i]) << NUM_SH) + 64'(in_item.root >> 1)) : '0;
        nx.drem[i] = nd[63:32];
        nx.dlo[i]  = nd[31:0];
        nx.quo[i]  = '0;
      end
      nx.dden = in_item.root;
    end

    // restoring division, one quotient bit per cell
    if (DO_DIV) begin
      for (int i = 0; i < 4; i++) begin
        tq = {in_item.drem[i], in_item.dlo[i][31]};
        if (tq >= {1'b0, in_item.dden}) begin
          tq = tq - {1'b0, in_item.dden};
          nx.quo[i] = {in_item.quo[i][30:0], 1'b1};
        end else begin
          nx.quo[i] = {in_item.quo[i][30:0], 1'b0};
        end
        nx.drem[i] = tq[31:0];
        nx.dlo[i]  = {in_item.dlo[i][30:0], 1'b0};
      end
    end

    // reduce the half angle modulo two pi
    if (DO_MOD) begin
      if (in_item.h >= MOD_C) nx.h = in_item.h - MOD_C;
    end

    // fold into [-pi/2, pi/2]
    if (STEP == S_FOLD) begin
      tt = $signed({3'b000, in_item.h[32:0]});
      if (tt > PI_S) tt = tt - TWO_PI_S;
      if (tt > HALF_PI_S) begin
        tt   = tt - PI_S;
        fneg = 1'b1;
      end else if (tt < -HALF_PI_S) begin
        tt   = tt + PI_S;
        fneg = 1'b1;
      end
      nx.cx   = CORDIC_START;
      nx.cy   = '0;
      nx.cz   = tt;
      nx.cneg = fneg;
    end

    // CORDIC rotation
    if (DO_CORD) begin
      at = $signed({4'd0, ATAN_TAB[CORD_I]});
      if (in_item.cz >= 0) begin
        nx.cx = in_item.cx - (in_item.cy >>> CORD_I);
        nx.cy = in_item.cy + (in_item.cx >>> CORD_I);
        nx.cz = in_item.cz - at;
      end else begin
        nx.cx = in_item.cx + (in_item.cy >>> CORD_I);
        nx.cy = in_item.cy - (in_item.cx >>> CORD_I);
        nx.cz = in_item.cz + at;
      end
    end

    // sign fix and clamp of cos and sin
    if (STEP == E + E_SIN) begin
      tt = in_item.cneg ? -in_item.cx : in_item.cx;
      if (tt > ONE_S) tt = ONE_S;
      if (tt < -ONE_S) tt = -ONE_S;
      nx.dq[0] = tt[31:0];
      tt = in_item.cneg ? -in_item.cy : in_item.cy;
      if (tt > ONE_S) tt = ONE_S;
      if (tt < -ONE_S) tt = -ONE_S;
      nx.sneg = tt[35];
      at = tt[35] ? -tt : tt;
      nx.sm = at[31:0];
    end

    if (STEP == E + E_MULS) begin
      for (int i = 0; i < 3; i++) begin
        nx.sq[i] = 62'(in_item.quo[i][30:0]) * 62'(in_item.sm[30:0]);
      end
    end

    // vector part of the delta quaternion
    if (STEP == E + E_DQ) begin
      for (int i = 0; i < 3; i++) begin
        vv  = 64'(in_item.sq[i]) + 64'd536870912;
        v32 = vv[61:30];
        nx.dq[i + 1] = (in_item.rvneg[i] ^ in_item.sneg) ? (32'd0 - v32) : v32;
      end
      if (in_item.rvzero) begin
        nx.dq[0] = ONE_Q30;
        nx.dq[1] = '0;
        nx.dq[2] = '0;
        nx.dq[3] = '0;
      end
    end

    // sixteen partial products of q * dq, quartered
    if (STEP == E + E_PROD) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp = $signed(in_item.q[i]) * $signed(in_item.dq[j]);
          nx.pt[4 * i + j] = pp[63:2];
        end
      end
    end

    // Hamilton product sums, magnitudes and their maximum
    if (STEP == E + E_PSUM) begin
      ps[0] = sx62(in_item.pt[0]) - sx62(in_item.pt[5]) - sx62(in_item.pt[10]) -
              sx62(in_item.pt[15]);
      ps[1] = sx62(in_item.pt[1]) + sx62(in_item.pt[4]) + sx62(in_item.pt[11]) -
              sx62(in_item.pt[14]);
      ps[2] = sx62(in_item.pt[2]) - sx62(in_item.pt[7]) + sx62(in_item.pt[8]) +
              sx62(in_item.pt[13]);
      ps[3] = sx62(in_item.pt[3]) + sx62(in_item.pt[6]) - sx62(in_item.pt[9]) +
              sx62(in_item.pt[12]);
      for (int i = 0; i < 4; i++) begin
        vv = ps[i][63] ? (64'd0 - ps[i]) : ps[i];
        nx.pneg[i] = ps[i][63];
        nx.mag[i]  = vv[61:0];
      end
      nx.pzero = (ps[0] == '0) && (ps[1] == '0) && (ps[2] == '0) && (ps[3] == '0);
      nx.mx = nx.mag[0];
      if (nx.mag[1] > nx.mx) nx.mx = nx.mag[1];
      if (nx.mag[2] > nx.mx) nx.mx = nx.mag[2];
      if (nx.mag[3] > nx.mx) nx.mx = nx.mag[3];
    end

    // signed, normalized result
    if (STEP == E + E_OUT) begin
      for (int i = 0; i < 4; i++) begin
        if (in_item.pzero) nx.res[i] = '0;
        else nx.res[i] = in_item.pneg[i] ? (32'd0 - in_item.quo[i]) : in_item.quo[i];
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= nx;
    end
  end

endmodule

// ===== design/quaternion_gyro_integrate_unit.sv =====
`timescale 1ns / 1ps
// Top level of the quaternion gyro integrator: stream ports, period register
// and the chain of qgi_cell stages. Depends on qgi_pkg and qgi_cell.
//
//   channel  | group                      | carries
//   ---------+----------------------------+---------------------------------
//   s_axis   | s_tvalid s_tready s_tdata  | attitude quaternion, body rate
//   m_axis   | m_tvalid m_tready m_tdata  | propagated unit quaternion
//   cfg      | cfg_valid cfg_ready cfg_data | sample period, Q0.32 s
//
// One request accepted per cycle while the result is not stalled; the delay to the
// result is set by the length of the cell chain.
// Reset clears every stage valid and loads the period with about 1 ms.
// A stalled result freezes the whole chain, so s_tready falls only while
// m_tvalid is high and m_tready is low.
module quaternion_gyro_integrate_unit
  import qgi_pkg::*;
#(
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // att_w, att_x, att_y, att_z, rate_x, rate_y, rate_z from bit 0 up
  input  logic [223:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_w, new_x, new_y, new_z from bit 0 up
  output logic [127:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  localparam int NUM = num_stages(CORDIC_STEPS);
  localparam logic signed [31:0] ONE_OUT = 32'sd1 <<< FRAC_BITS;

  logic [31:0]    period;
  logic           en;
  item_t          item_in;
  item_t          items [NUM + 1];
  logic [NUM:0]   vld;

  // Period register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_valid) begin
      period <= cfg_data;
    end
  end

  // Input item
  always_comb begin
    item_in = '0;
    for (int i = 0; i < 4; i++) item_in.q[i] = s_tdata[32 * i +: 32];
    for (int i = 0; i < 3; i++) item_in.rate[i] = s_tdata[128 + 32 * i +: 32];
  end

  assign items[0] = item_in;
  assign vld[0]   = s_tvalid;

  // Chain advances unless the result waits
  assign en       = !vld[NUM] || m_tready;
  assign s_tready = en;

  for (genvar s = 0; s < NUM; s++) begin : g_cell
    qgi_cell #(
      .STEP (s),
      .CS   (CORDIC_STEPS),
      .FRAC (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .period   (period),
      .in_item  (items[s]),
      .in_vld   (vld[s]),
      .out_item (items[s + 1]),
      .out_vld  (vld[s + 1])
    );
  end

  // Result
  assign m_tvalid = vld[NUM];
  assign m_tdata  = {items[NUM].res[3], items[NUM].res[2], items[NUM].res[1],
                     items[NUM].res[0]};

  // Checks
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("chain accepted a request while the result was stalled");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= ONE_OUT && $signed(m_tdata[31:0]) >= -ONE_OUT &&
                  $signed(m_tdata[127:96]) <= ONE_OUT &&
                  $signed(m_tdata[127:96]) >= -ONE_OUT))
    else $error("normalized component out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

// ===== bench/quaternion_gyro_integrate_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for quaternion_gyro_integrate_unit: directed and random attitude propagation
// requests, each checked against a typed result or a fixed-point predictor of the block.
// Depends on qgi_pkg and the design under test.
module quaternion_gyro_integrate_unit_tb;
  import qgi_pkg::*;

  localparam logic [31:0] ONE  = 32'h4000_0000;
  localparam logic [31:0] MONE = 32'hC000_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [31:0] HALF = 32'h2000_0000;
  localparam longint unsigned TWO_PI_U = 64'd6746518852;
  localparam longint PI_L      = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint ANGLE_ONE = 64'sd1073741824;
  localparam int STEPS   = DEF_CORDIC_STEPS;
  localparam int SETTLE  = 170;
  localparam int WD_LIMIT = 20000;
  localparam int PHASE_ITEMS = 175;

  typedef struct packed {
    logic [31:0] w, x, y, z;
  } quat_t;

  typedef struct packed {
    logic [31:0] w, x, y, z, rx, ry, rz;
    bit          known;
    quat_t       res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [223:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  quat_t       expected_quats[$];
  logic [31:0] cur_period = PERIOD_RESET;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          cfg_writes = 0;

  quaternion_gyro_integrate_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed requests; typed results only where they are obvious
  row_t dir_tab [16] = '{
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0}},
    '{ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{ONE, 32'd0, 32'd0, 32'd0}},
    '{MONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{MONE, 32'd0, 32'd0, 32'd0}},
    '{32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 32'd0, ONE}},
    '{SMAX, SMAX, SMAX, SMAX, 32'd0, 32'd0, 32'd0, 1'b1, '{HALF, HALF, HALF, HALF}},
    '{32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 32'd0, ONE}},
    '{32'd0, 32'd0, 32'd0, 32'd0, SMAX, SMIN, SMAX, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0}},
    '{SMIN, SMIN, SMIN, SMIN, 32'd0, 32'd0, 32'd0, 1'b0, '0},
    '{ONE, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 1'b0, '0},
    '{ONE, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0, '0},
    '{ONE, 32'd0, 32'd0, 32'd0, 32'd1000000, 32'd0, 32'd0, 1'b0, '0},
    '{ONE, 32'd0, 32'd0, 32'd0, 32'd0, SMAX, 32'd0, 1'b0, '0},
    '{ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, SMIN, 1'b0, '0},
    '{ONE, ONE, ONE, ONE, SMAX, SMAX, SMAX, 1'b0, '0},
    '{ONE, 32'd0, 32'd0, 32'd0, SMIN, SMIN, SMIN, 1'b0, '0},
    '{SMAX, SMIN, SMAX, SMIN, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000, 1'b0, '0}
  };

  // Shift magnitudes so the largest lies in [2^30, 2^31); returns the right shift
  function automatic int align_mags(inout longint unsigned m[4], input int cnt);
    longint unsigned mx;
    int k;
    mx = 0;
    k = 0;
    for (int i = 0; i < cnt; i++) if (m[i] > mx) mx = m[i];
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 31)) begin mx >>= 1; k++; end
    while (mx < (64'd1 << 30)) begin mx <<= 1; k--; end
    for (int i = 0; i < cnt; i++) begin
      if (k > 0) m[i] >>= k;
      else m[i] <<= -k;
    end
    return k;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > ANGLE_ONE) return ANGLE_ONE;
    if (v < -ANGLE_ONE) return -ANGLE_ONE;
    return v;
  endfunction

  // CORDIC sine and cosine of a Q.30 half angle in [0, 2pi)
  function automatic void half_sincos(input longint t, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    x = 64'sd652032874;
    y = 0;
    flip = 1'b0;
    if (t > PI_L) t -= longint'(TWO_PI_U);
    if (t > HALF_PI_L) begin
      t -= PI_L;
      flip = 1'b1;
    end else if (t < -HALF_PI_L) begin
      t += PI_L;
      flip = 1'b1;
    end
    z = t;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_unit(x);
    s = clamp_unit(y);
  endfunction

  // Attitude after one step: normalised q * dq
  function automatic quat_t propagate_attitude(row_t r, logic [31:0] period);
    longint q[4], rv[3], dq[4], p[4], rate[3];
    longint unsigned m[4];
    longint unsigned n, a, h, sm, u;
    longint c, s, v;
    int k;
    quat_t res;
    q[0] = longint'(signed'(r.w));
    q[1] = longint'(signed'(r.x));
    q[2] = longint'(signed'(r.y));
    q[3] = longint'(signed'(r.z));
    rate[0] = longint'(signed'(r.rx));
    rate[1] = longint'(signed'(r.ry));
    rate[2] = longint'(signed'(r.rz));
    for (int i = 0; i < 3; i++)
      rv[i] = (rate[i] * longint'({32'd0, period}) + (64'sd1 <<< 21)) >>> 22;
    if (rv[0] == 0 && rv[1] == 0 && rv[2] == 0) begin
      // rotation below one LSB: identity delta
      dq[0] = ANGLE_ONE;
      dq[1] = 0;
      dq[2] = 0;
      dq[3] = 0;
    end else begin
      for (int i = 0; i < 3; i++) m[i] = mag64(rv[i]);
      m[3] = 0;
      k = align_mags(m, 3);
      n = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      a = (k >= 0) ? (n << k) : (n >> -k);
      h = (a + 1) >> 1;
      half_sincos(longint'(h % TWO_PI_U), c, s);
      dq[0] = c;
      sm = mag64(s);
      for (int i = 0; i < 3; i++) begin
        u = ((m[i] << 30) + (n >> 1)) / n;
        v = longint'((u * sm + (64'd1 << 29)) >> 30);
        dq[1 + i] = ((rv[i] < 0) != (s < 0)) ? -v : v;
      end
    end
    p[0] = ((q[0] * dq[0]) >>> 2) - ((q[1] * dq[1]) >>> 2) - ((q[2] * dq[2]) >>> 2)
         - ((q[3] * dq[3]) >>> 2);
    p[1] = ((q[0] * dq[1]) >>> 2) + ((q[1] * dq[0]) >>> 2) + ((q[2] * dq[3]) >>> 2)
         - ((q[3] * dq[2]) >>> 2);
    p[2] = ((q[0] * dq[2]) >>> 2) - ((q[1] * dq[3]) >>> 2) + ((q[2] * dq[0]) >>> 2)
         + ((q[3] * dq[1]) >>> 2);
    p[3] = ((q[0] * dq[3]) >>> 2) + ((q[1] * dq[2]) >>> 2) - ((q[2] * dq[1]) >>> 2)
         + ((q[3] * dq[0]) >>> 2);
    // zero product passes through as zero
    if (p[0] == 0 && p[1] == 0 && p[2] == 0 && p[3] == 0) return '0;
    for (int i = 0; i < 4; i++) m[i] = mag64(p[i]);
    void'(align_mags(m, 4));
    n = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2] + m[3] * m[3]);
    for (int i = 0; i < 4; i++) begin
      u = ((m[i] << DEF_FRAC_BITS) + (n >> 1)) / n;
      v = (p[i] < 0) ? -longint'(u) : longint'(u);
      case (i)
        0: res.w = v[31:0];
        1: res.x = v[31:0];
        2: res.y = v[31:0];
        default: res.z = v[31:0];
      endcase
    end
    return res;
  endfunction

  // Send one request; the expectation is queued at acceptance
  task automatic send_request(row_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.rz, r.ry, r.rx, r.z, r.y, r.x, r.w};
    do @(posedge clk); while (!s_tready);
    expected_quats.push_back(r.known ? r.res : propagate_attitude(r, cur_period));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_quats.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_period(logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_period = val;
    cfg_writes++;
  endtask

  // Random request: rates full range half the time, else mostly small, some zero
  function automatic row_t random_request();
    row_t r;
    int sel;
    r = '0;
    sel = $urandom_range(9);
    if (sel < 5) begin
      r.w = $urandom; r.x = $urandom; r.y = $urandom; r.z = $urandom;
    end else begin
      // attitude with each component within [-0.5, 0.5]
      r.w = $urandom_range(32'h4000_0000) - 32'h2000_0000;
      r.x = $urandom_range(32'h4000_0000) - 32'h2000_0000;
      r.y = $urandom_range(32'h4000_0000) - 32'h2000_0000;
      r.z = $urandom_range(32'h4000_0000) - 32'h2000_0000;
    end
    sel = $urandom_range(9);
    if (sel < 5) begin
      r.rx = $urandom; r.ry = $urandom; r.rz = $urandom;
    end else if (sel < 9) begin
      r.rx = $urandom_range(32'h0080_0000) - 32'h0040_0000;
      r.ry = $urandom_range(32'h0080_0000) - 32'h0040_0000;
      r.rz = $urandom_range(32'h0080_0000) - 32'h0040_0000;
    end
    return r;
  endfunction

  // Result checker, receiver stalls and watchdog
  always @(posedge clk) begin
    quat_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_quats.size());
        $display("simulation failed");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        // new_w sits in the lowest bits of m_tdata
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96]};
        results_seen <= results_seen + 1;
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_quats.pop_front();
          if (got.w !== want.w || got.x !== want.x || got.y !== want.y || got.z !== want.z)
          begin
            $display("%0t: result mismatch expected w=%h x=%h y=%h z=%h", $time,
                     want.w, want.x, want.y, want.z);
            $display("%0t:                   actual w=%h x=%h y=%h z=%h", $time,
                     got.w, got.x, got.y, got.z);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Stimulus: directed table, then random phases over periods and idling modes
  initial begin
    logic [31:0] periods [8];
    periods = '{PERIOD_RESET, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd42949673,
                32'hFFFF_FFFF, 32'd0, PERIOD_RESET};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) send_request(dir_tab[i]);
    drain_results();
    for (int ph = 0; ph < 8; ph++) begin
      if (periods[ph] == 0) periods[ph] = $urandom_range(32'hFFFF_FFFF, 1);
      write_period(periods[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
      drain_results();
    end
    $display("Covered %0d directed and %0d random requests, %0d period writes,",
             $size(dir_tab), 8 * PHASE_ITEMS, cfg_writes);
    $display("%0d results checked with %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
